>>> src/rgt_pkg.sv
// Shared types, constants and small arithmetic helpers for the RGB565 gray tint block.
// No dependencies; used by rgt_div and rgb565_gray_tint.
package rgt_pkg;

  // Luminance weights, Q16 scaled so that the sum lands on 0..255.0
  localparam logic [23:0] WEIGHT_R = 24'd161187;
  localparam logic [23:0] WEIGHT_G = 24'd155710;
  localparam logic [23:0] WEIGHT_B = 24'd61456;

  // 128.0 and 255.0 in Q16
  localparam logic [23:0] LUM_MID  = 24'd8388608;
  localparam logic [23:0] LUM_FULL = 24'd16711680;

  // Unity weight in Q16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Pipelined divider geometry: numerator, denominator and quotient widths
  localparam int DIV_NW = 25;
  localparam int DIV_DW = 9;
  localparam int DIV_QW = 17;

  // Exact reciprocal multipliers for division by 5
  localparam logic [26:0] DIV5_MAGIC_26 = 27'd107374183;  // ceil(2^29 / 5)
  localparam logic [15:0] DIV5_MAGIC_16 = 16'd52429;      // ceil(2^18 / 5)

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_INTENSITY  = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_SELECTIVE  = 2'd2,
    REG_TINT_COLOR = 2'd3
  } rgt_reg_t;

  // Source of the blend weight
  typedef enum logic [1:0] {
    WSEL_FULL = 2'd0,  // full intensity
    WSEL_QUO  = 2'd1,  // divider quotient
    WSEL_QUO5 = 2'd2   // divider quotient over five
  } rgt_wsel_t;

  // Side data that travels alongside the divider
  typedef struct packed {
    logic [15:0] px;
    logic        bypass;
    logic [4:0]  gr;
    logic [5:0]  gg;
    logic [16:0] bq;
    rgt_wsel_t   wsel;
  } rgt_tag_t;

  // Floor of x / 5 for x below 2^26
  function automatic logic [23:0] div5_26(input logic [25:0] x);
    logic [52:0] p;
    p = 53'(x) * 53'(DIV5_MAGIC_26);
    return p[52:29];
  endfunction

  // Floor of x / 5 for 16-bit x
  function automatic logic [13:0] div5_16(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(DIV5_MAGIC_16);
    return p[31:18];
  endfunction

  // Floor of x / 255 for 14-bit x: reciprocal estimate, then one correction
  function automatic logic [6:0] div255_14(input logic [13:0] x);
    logic [29:0] p;
    logic [6:0]  q0;
    logic [13:0] r;
    p  = 30'(x) * 30'(257);
    q0 = p[22:16];
    r  = x - 14'(14'(q0) * 14'd255);
    return (r >= 14'd255) ? q0 + 7'd1 : q0;
  endfunction

endpackage

>>> src/rgb565_gray_tint.sv
// Top level of the RGB565 gray tint pipeline: configuration registers and all stages.
// Depends on rgt_pkg and rgt_div.
//
// One pixel is taken at every clock edge at which start is high; busy is never
// raised, so the block sustains one pixel per clock. Each result appears on
// pixel_out with done high for one cycle, in input order; the receiver cannot
// stall it. The pipeline holds eight front stages (luminance, contrast, gray
// and brightness, weight operands), the 17-stage weight divider and three back
// stages (weight, brightness scaling, blend). Configuration writes take effect
// at once and are meant for times when no pixel is in flight.
module rgb565_gray_tint (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] pixel_in,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] pixel_out
);

  // Configuration registers
  logic [8:0]  intensity_q;
  logic [8:0]  threshold_q;
  logic        selective_q;
  logic [15:0] tint_color_q;

  // Clamped intensity and threshold, 1/256 units
  logic [8:0]  int_c;
  logic [8:0]  thr_c;
  logic [16:0] tw;
  logic [16:0] iw;

  // Stage registers
  logic        v1, v2, v3, v4, v5, v6, v7, v8;
  logic [15:0] px1, px2, px3, px4, px5, px6, px7;
  logic [23:0] lum1;
  logic        neg2, neg3;
  logic [25:0] mag2;
  logic [23:0] q3;
  logic [23:0] cq4, cq5;
  logic [12:0] g31_5;
  logic [13:0] g63_5;
  logic [16:0] bq0_5;
  logic [4:0]  gr6, gr7;
  logic [5:0]  gg6, gg7;
  logic [16:0] bq6, bq7;
  logic [16:0] mr7, mg7;
  logic [24:0] num8;
  logic [8:0]  den8;
  rgt_pkg::rgt_tag_t tag8;

  // Divider output and back stages
  logic              dv;
  logic [16:0]       quo;
  rgt_pkg::rgt_tag_t dtag;
  logic              va, vb;
  logic [16:0]       w0a, wb;
  rgt_pkg::rgt_tag_t taga, tagb;

  // Combinational stage values
  logic [23:0] lum_next;
  logic [23:0] mag_abs;
  logic [25:0] sum4;
  logic [23:0] cq_next;
  logic [28:0] p31;
  logic [29:0] p63;
  logic [40:0] pbq;
  logic [24:0] bq_rem;
  logic [16:0] bq_next;
  logic [9:0]  gy;
  logic [15:0] gy65;
  logic [9:0]  gy_rem;
  logic [4:0]  mg_frac;
  logic [4:0]  mr_frac;
  logic [16:0] m7;
  logic [16:0] a8;
  logic [8:0]  den8_next;
  rgt_pkg::rgt_wsel_t wsel8;
  logic [25:0] prod8;
  logic [16:0] w0_next;
  logic [33:0] prodb;
  logic [16:0] wb_next;
  logic [4:0]  out_r;
  logic [5:0]  out_g;
  logic [4:0]  out_b;

  // Blend one channel toward the tint and cap it
  function automatic logic [5:0] mix(input logic [5:0] gray, input logic [5:0] tint,
                                     input logic [16:0] w, input logic [5:0] cap);
    logic [22:0] p;
    logic [6:0]  v;
    p = 23'(gray) * 23'(rgt_pkg::ONE_Q16 - w) + 23'(tint) * 23'(w);
    v = p[22:16];
    return (v > 7'(cap)) ? cap : v[5:0];
  endfunction

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_q  <= '0;
      threshold_q  <= '0;
      selective_q  <= 1'b0;
      tint_color_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgt_pkg::REG_INTENSITY:  intensity_q  <= cfg_data[8:0];
        rgt_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data[8:0];
        rgt_pkg::REG_SELECTIVE:  selective_q  <= cfg_data[0];
        rgt_pkg::REG_TINT_COLOR: tint_color_q <= cfg_data;
        default: ;
      endcase
    end
  end

  assign int_c = (intensity_q > 9'd256) ? 9'd256 : intensity_q;
  assign thr_c = (threshold_q > 9'd256) ? 9'd256 : threshold_q;
  assign tw    = {thr_c, 8'd0};
  assign iw    = {int_c, 8'd0};

  // Stage 1: luminance
  assign lum_next = 24'(pixel_in[15:11]) * rgt_pkg::WEIGHT_R
                  + 24'(pixel_in[10:5])  * rgt_pkg::WEIGHT_G
                  + 24'(pixel_in[4:0])   * rgt_pkg::WEIGHT_B;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    px1  <= pixel_in;
    lum1 <= lum_next;
  end

  // Stage 2: distance from mid gray, times six
  assign mag_abs = (lum1 < rgt_pkg::LUM_MID) ? rgt_pkg::LUM_MID - lum1
                                             : lum1 - rgt_pkg::LUM_MID;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    px2  <= px1;
    neg2 <= (lum1 < rgt_pkg::LUM_MID);
    mag2 <= 26'(mag_abs) * 26'd6;
  end

  // Stage 3: divide by five, truncating the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    px3  <= px2;
    neg3 <= neg2;
    q3   <= rgt_pkg::div5_26(mag2);
  end

  // Stage 4: re-center and clamp to 0..255.0
  always_comb begin
    sum4 = neg3 ? 26'(rgt_pkg::LUM_MID) - 26'(q3) : 26'(rgt_pkg::LUM_MID) + 26'(q3);
    priority if (sum4[25]) begin
      cq_next = '0;
    end else if (sum4[24:0] > 25'(rgt_pkg::LUM_FULL)) begin
      cq_next = rgt_pkg::LUM_FULL;
    end else begin
      cq_next = sum4[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    px4 <= px3;
    cq4 <= cq_next;
  end

  // Stage 5: gray and brightness estimates
  assign p31 = 29'(cq4) * 29'd31;
  assign p63 = 30'(cq4) * 30'd63;
  assign pbq = 41'(cq4) * 41'd65793;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    px5   <= px4;
    cq5   <= cq4;
    g31_5 <= p31[28:16];
    g63_5 <= p63[29:16];
    bq0_5 <= pbq[40:24];
  end

  // Stage 6: correct the gray levels and brightness
  assign bq_rem  = 25'(cq5) - 25'(bq0_5) * 25'd255;
  assign bq_next = (bq_rem >= 25'd255) ? bq0_5 + 17'd1 : bq0_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    px6 <= px5;
    gr6 <= 5'(rgt_pkg::div255_14(14'(g31_5)));
    gg6 <= 6'(rgt_pkg::div255_14(g63_5));
    bq6 <= bq_next;
  end

  // Stage 7: gray components back to Q16 fractions
  assign mr_frac = (gr6 == 5'd31) ? 5'd2 : (gr6[4] ? 5'd1 : 5'd0);
  assign gy      = 10'(gg6) << 4;
  assign gy65    = 16'(gy) * 16'd65;
  assign gy_rem  = gy - 10'(10'(gy65[15:12]) * 10'd63);
  assign mg_frac = (gy_rem >= 10'd63) ? 5'(gy65[15:12]) + 5'd1 : 5'(gy65[15:12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    px7 <= px6;
    gr7 <= gr6;
    gg7 <= gg6;
    bq7 <= bq6;
    mr7 <= 17'(gr6) * 17'd2114 + 17'(mr_frac);
    mg7 <= 17'(gg6) * 17'd1040 + 17'(mg_frac);
  end

  // Stage 8: pick the weight rule and form the divider operands
  always_comb begin
    a8        = '0;
    den8_next = 9'd1;
    wsel8     = rgt_pkg::WSEL_FULL;
    m7        = (mg7 < mr7) ? mg7 : mr7;
    priority if (selective_q) begin
      priority if (bq7 < tw) begin
        a8        = bq7;
        den8_next = thr_c;
        wsel8     = rgt_pkg::WSEL_QUO5;
      end else if (thr_c != 9'd256) begin
        a8        = bq7 - tw;
        den8_next = 9'd256 - thr_c;
        wsel8     = rgt_pkg::WSEL_QUO;
      end else begin
        wsel8     = rgt_pkg::WSEL_FULL;
      end
    end else if (thr_c != '0 && m7 < tw) begin
      a8        = m7;
      den8_next = thr_c;
      wsel8     = rgt_pkg::WSEL_QUO5;
    end else begin
      wsel8     = rgt_pkg::WSEL_FULL;
    end
    prod8 = 26'(int_c) * 26'(a8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    num8        <= prod8[24:0];
    den8        <= den8_next;
    tag8.px     <= px7;
    tag8.bypass <= (int_c == '0);
    tag8.gr     <= gr7;
    tag8.gg     <= gg7;
    tag8.bq     <= bq7;
    tag8.wsel   <= wsel8;
  end

  rgt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .in_num    (num8),
    .in_den    (den8),
    .in_tag    (tag8),
    .out_valid (dv),
    .out_quo   (quo),
    .out_tag   (dtag)
  );

  // Stage A: final blend weight before brightness scaling
  always_comb begin
    unique case (dtag.wsel)
      rgt_pkg::WSEL_QUO5: w0_next = 17'(rgt_pkg::div5_16(quo[15:0]));
      rgt_pkg::WSEL_QUO:  w0_next = quo;
      default:            w0_next = iw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= dv;
    end
    w0a  <= w0_next;
    taga <= dtag;
  end

  // Stage B: scale the weight by brightness
  assign prodb   = 34'(w0a) * 34'(taga.bq);
  assign wb_next = (prodb[33:16] > 18'(rgt_pkg::ONE_Q16)) ? rgt_pkg::ONE_Q16 : prodb[32:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    wb   <= wb_next;
    tagb <= taga;
  end

  // Output: blend toward the tint, or pass the pixel when intensity is zero
  assign out_r = 5'(mix(6'(tagb.gr), 6'(tint_color_q[15:11]), wb, 6'd31));
  assign out_g = mix(tagb.gg, tint_color_q[10:5], wb, 6'd63);
  assign out_b = 5'(mix(6'(tagb.gr), 6'(tint_color_q[4:0]), wb, 6'd31));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
    if (vb && !rst) begin
      pixel_out <= tagb.bypass ? tagb.px : {out_r, out_g, out_b};
    end
  end

endmodule

>>> src/rgt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rgt_pkg for the widths and the side data type.
module rgt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rgt_pkg::DIV_NW-1:0]   in_num,
  input  logic [rgt_pkg::DIV_DW-1:0]   in_den,
  input  rgt_pkg::rgt_tag_t            in_tag,
  output logic                         out_valid,
  output logic [rgt_pkg::DIV_QW-1:0]   out_quo,
  output rgt_pkg::rgt_tag_t            out_tag
);

  localparam int NW = rgt_pkg::DIV_NW;
  localparam int DW = rgt_pkg::DIV_DW;
  localparam int QW = rgt_pkg::DIV_QW;

  logic [QW-1:0]     vld;
  logic [NW-1:0]     rem [QW];
  logic [DW-1:0]     den [QW];
  logic [QW-1:0]     quo [QW];
  rgt_pkg::rgt_tag_t tag [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    logic              vld_prev;
    logic [NW-1:0]     rem_prev;
    logic [DW-1:0]     den_prev;
    logic [QW-1:0]     quo_prev;
    rgt_pkg::rgt_tag_t tag_prev;
    logic [NW-1:0]     dsh;
    logic              ge;

    if (s == 0) begin : g_head
      assign vld_prev = in_valid;
      assign rem_prev = in_num;
      assign den_prev = in_den;
      assign quo_prev = '0;
      assign tag_prev = in_tag;
    end else begin : g_body
      assign vld_prev = vld[s-1];
      assign rem_prev = rem[s-1];
      assign den_prev = den[s-1];
      assign quo_prev = quo[s-1];
      assign tag_prev = tag[s-1];
    end

    // Trial subtract of the shifted divisor decides this quotient bit
    assign dsh = NW'(den_prev) << B;
    assign ge  = (rem_prev >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_prev;
      end
      rem[s] <= ge ? rem_prev - dsh : rem_prev;
      den[s] <= den_prev;
      quo[s] <= ge ? (quo_prev | (QW'(1) << B)) : quo_prev;
      tag[s] <= tag_prev;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_tag   = tag[QW-1];

endmodule

>>> src/rgt_check.sv
// Port-level timing checks for rgb565_gray_tint, attached through a bind.
// Depends only on the top level's ports.
module rgt_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] pixel_out
);

  localparam int LATENCY = 28;

  // Every accepted beat must produce a result strobe on done at the expected cycle
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted beat produced no result at the expected cycle");

  // No result without a matching beat accepted earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("result shown without a matching accepted beat");

  // Hold the last result when the strobe drops
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    $fell(done) |-> $stable(pixel_out))
    else $error("pixel_out changed without a result strobe");

endmodule

bind rgb565_gray_tint rgt_check u_rgt_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .pixel_out (pixel_out)
);
